// File: hw/rtl/cpc_pkg.sv
// ----------------------------------------------------------------------------
// cpc_pkg: shared types and constants of the coulomb pulse counter
// Field widths, command and register codes, the control state type and the
// status bundle of the serial divider.
// ----------------------------------------------------------------------------
package cpc_pkg;

  localparam int CMD_W   = 2;
  localparam int SEC_W   = 32;
  localparam int CNT_W   = 32;
  localparam int MC_W    = 32;
  localparam int AVG_W   = 16;
  localparam int PPAH_W  = 16;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 16;

  // millicoulombs per ampere hour
  localparam int           MC_W_CONST = 22;
  localparam logic [21:0]  MC_PER_AH  = 22'd3600000;
  localparam logic [3:0]   DECI_PER_MILLI = 4'd10;

  // divider: dividend holds count * 3600000 + half divisor
  localparam int DVD_W  = CNT_W + MC_W_CONST;
  localparam int DVS_W  = 32;
  localparam int QUO_W  = 32;
  localparam int STEP_W = $clog2(DVD_W);

  localparam logic [CMD_W-1:0] CMD_PULSE    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RESET    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ_CHG = 2'd2;
  localparam logic [CMD_W-1:0] CMD_READ_AVG = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_PPAH     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POLARITY = 1'd1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CONV_C,
    S_WAIT_C,
    S_CONV_D,
    S_WAIT_D,
    S_AVG,
    S_WAIT_A,
    S_OUT
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// File: hw/rtl/cpc_if.sv
// ----------------------------------------------------------------------------
// cpc_if: channel interfaces of the coulomb pulse counter
// Command channel, result channel and register write channel, each with
// valid/ready and a source and a sink side.
// ----------------------------------------------------------------------------
interface cpc_req_if;
  logic                      valid;
  logic                      ready;
  logic [cpc_pkg::CMD_W-1:0] command;
  logic                      polarity_level;
  logic [cpc_pkg::SEC_W-1:0] now_seconds;

  modport source (output valid, command, polarity_level, now_seconds, input ready);
  modport sink   (input valid, command, polarity_level, now_seconds, output ready);
endinterface

interface cpc_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [cpc_pkg::MC_W-1:0]         charge_millicoulomb;
  logic [cpc_pkg::MC_W-1:0]         discharge_millicoulomb;
  logic signed [cpc_pkg::AVG_W-1:0] avg_current_deci_ma;
  logic                             status;

  modport source (output valid, charge_millicoulomb, discharge_millicoulomb,
                  avg_current_deci_ma, status, input ready);
  modport sink   (input valid, charge_millicoulomb, discharge_millicoulomb,
                  avg_current_deci_ma, status, output ready);
endinterface

interface cpc_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [cpc_pkg::CFG_IDX_W-1:0] index;
  logic [cpc_pkg::CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: hw/rtl/coulomb_pulse_counter.sv
// ----------------------------------------------------------------------------
// coulomb_pulse_counter: coulomb-counter pulse accumulator
// Counts charge and discharge pulses and converts them to millicoulombs and
// an average current on request.
// ----------------------------------------------------------------------------
// Pulse and reset commands give no result. A charge read runs two passes
// through a bit-serial divider that produces one quotient bit per cycle over
// a 54-bit dividend; an average-current read runs a third pass (none when
// no time has elapsed). The finished word waits in an output register, so
// the next command is taken while it is still held.
module coulomb_pulse_counter (
  input  logic   clk,
  input  logic   rst,
  cpc_req_if.sink   req,
  cpc_rsp_if.source rsp,
  cpc_cfg_if.sink   cfg
);
  import cpc_pkg::*;

  state_t state, state_next;

  logic [PPAH_W-1:0] ppah;
  logic              pol_present;
  logic [CNT_W-1:0]  charge_cnt;
  logic [CNT_W-1:0]  discharge_cnt;
  logic [SEC_W-1:0]  origin_sec;
  logic [SEC_W-1:0]  last_sec;

  logic              is_avg;
  logic              neg;
  logic [MC_W-1:0]   cmc;
  logic [MC_W-1:0]   dmc;
  logic [AVG_W-1:0]  avg;
  logic              stat_bit;

  logic              rsp_valid;
  logic [MC_W-1:0]   rsp_cmc;
  logic [MC_W-1:0]   rsp_dmc;
  logic [AVG_W-1:0]  rsp_avg;
  logic              rsp_status;

  logic              accept;
  logic              div_start;
  div_stat_t         div_stat;
  logic [QUO_W-1:0]  div_quo;
  logic [DVD_W-1:0]  div_dvd;
  logic [DVS_W-1:0]  div_dvs;

  logic [CNT_W-1:0]  conv_count;
  logic [DVD_W-1:0]  prod;
  logic [MC_W-1:0]   diff;
  logic [MC_W-1:0]   diff10;
  logic [MC_W-1:0]   diff_mag;
  logic [SEC_W-1:0]  dur;
  logic [SEC_W-1:0]  dur_mag;
  logic              out_free;

  assign accept   = req.valid && req.ready;
  assign out_free = !rsp_valid || rsp.ready;

  // conversion dividend: count * 3600000 + half the divisor
  assign conv_count = (state == S_CONV_C) ? charge_cnt : discharge_cnt;
  assign prod       = DVD_W'(conv_count) * DVD_W'(MC_PER_AH) + DVD_W'(ppah >> 1);

  assign diff     = dmc - cmc;
  assign diff10   = MC_W'(diff * MC_W'(DECI_PER_MILLI));
  assign diff_mag = diff10[MC_W-1] ? MC_W'(-diff10) : diff10;
  assign dur      = last_sec - origin_sec;
  assign dur_mag  = dur[SEC_W-1] ? SEC_W'(-dur) : dur;

  always_comb begin
    if (state == S_AVG) begin
      div_dvd = DVD_W'(diff_mag);
      div_dvs = dur_mag;
    end else begin
      div_dvd = prod;
      div_dvs = DVS_W'(ppah);
    end
  end

  cpc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .stat     (div_stat),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req.ready  = 1'b0;
    div_start  = 1'b0;
    unique case (state)
      S_IDLE: begin
        req.ready = 1'b1;
        if (accept && (req.command == CMD_READ_CHG || req.command == CMD_READ_AVG)) begin
          state_next = S_CONV_C;
        end
      end
      S_CONV_C: begin
        div_start  = 1'b1;
        state_next = S_WAIT_C;
      end
      S_WAIT_C: begin
        if (div_stat.done) state_next = S_CONV_D;
      end
      S_CONV_D: begin
        div_start  = 1'b1;
        state_next = S_WAIT_D;
      end
      S_WAIT_D: begin
        if (div_stat.done) state_next = S_AVG;
      end
      S_AVG: begin
        if (is_avg && dur != '0) begin
          div_start  = 1'b1;
          state_next = S_WAIT_A;
        end else begin
          state_next = S_OUT;
        end
      end
      S_WAIT_A: begin
        if (div_stat.done) state_next = S_OUT;
      end
      S_OUT: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // counters, time stamps and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      ppah          <= PPAH_W'(3072);
      pol_present   <= 1'b1;
      charge_cnt    <= '0;
      discharge_cnt <= '0;
      origin_sec    <= '0;
      last_sec      <= '0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        unique case (cfg.index)
          CFG_PPAH:     ppah        <= cfg.data;
          CFG_POLARITY: pol_present <= cfg.data[0];
          default:      ;
        endcase
      end
      if (accept && req.command == CMD_PULSE) begin
        if (pol_present && req.polarity_level) begin
          charge_cnt <= charge_cnt + CNT_W'(1);
        end else begin
          discharge_cnt <= discharge_cnt + CNT_W'(1);
        end
        last_sec <= req.now_seconds;
      end else if (accept && req.command == CMD_RESET) begin
        charge_cnt    <= '0;
        discharge_cnt <= '0;
        origin_sec    <= req.now_seconds;
        last_sec      <= req.now_seconds;
      end
    end
  end

  // working registers of a read
  always_ff @(posedge clk) begin
    if (accept) is_avg <= (req.command == CMD_READ_AVG);
    if (state == S_WAIT_C && div_stat.done) cmc <= div_quo;
    if (state == S_WAIT_D && div_stat.done) dmc <= div_quo;
    if (state == S_AVG) begin
      neg      <= diff10[MC_W-1] ^ dur[SEC_W-1];
      avg      <= '0;
      stat_bit <= is_avg && dur == '0;
    end
    if (state == S_WAIT_A && div_stat.done) begin
      avg <= neg ? AVG_W'(-div_quo[AVG_W-1:0]) : div_quo[AVG_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == S_OUT && out_free) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      rsp_cmc    <= cmc;
      rsp_dmc    <= dmc;
      rsp_avg    <= avg;
      rsp_status <= stat_bit;
    end
  end

  assign rsp.valid                  = rsp_valid;
  assign rsp.charge_millicoulomb    = rsp_cmc;
  assign rsp.discharge_millicoulomb = rsp_dmc;
  assign rsp.avg_current_deci_ma    = rsp_avg;
  assign rsp.status                 = rsp_status;
  assign cfg.ready                  = 1'b1;

`ifndef SYNTHESIS
  a_read_starts: assert property (@(posedge clk) disable iff (rst)
    (accept && (req.command == CMD_READ_CHG || req.command == CMD_READ_AVG))
    |=> state == S_CONV_C)
    else $error("read command did not start a conversion");

  a_pulse_counts_one: assert property (@(posedge clk) disable iff (rst)
    (accept && req.command == CMD_PULSE)
    |=> CNT_W'(charge_cnt + discharge_cnt)
        == CNT_W'($past(CNT_W'(charge_cnt + discharge_cnt)) + 1'b1))
    else $error("pulse did not add exactly one count");

  a_reset_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && req.command == CMD_RESET)
    |=> charge_cnt == '0 && discharge_cnt == '0 && origin_sec == last_sec)
    else $error("reset command left counts or time stamps");

  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  a_out_only_when_free: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp.ready) |=> $stable(rsp_cmc) && $stable(rsp_avg))
    else $error("held result word changed");
`endif

endmodule

// File: hw/rtl/cpc_div.sv
// ----------------------------------------------------------------------------
// cpc_div: bit-serial unsigned divider
// Restoring division, one quotient bit per cycle over the full dividend
// width; keeps the low quotient bits. A zero divisor gives all ones.
// ----------------------------------------------------------------------------
module cpc_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [cpc_pkg::DVD_W-1:0]   dividend,
  input  logic [cpc_pkg::DVS_W-1:0]   divisor,
  output cpc_pkg::div_stat_t          stat,
  output logic [cpc_pkg::QUO_W-1:0]   quotient
);
  import cpc_pkg::*;

  logic [DVD_W-1:0]  dvd;
  logic [DVS_W-1:0]  dvs;
  logic [DVS_W-1:0]  rem;
  logic [QUO_W-1:0]  quo;
  logic [STEP_W-1:0] step;
  logic              busy;
  logic              done;

  logic [DVS_W:0]    trial;
  logic              qbit;
  logic [DVS_W:0]    trial_sub;

  assign trial     = {rem, dvd[DVD_W-1]};
  assign qbit      = trial >= {1'b0, dvs};
  assign trial_sub = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && step == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd  <= dividend;
      dvs  <= divisor;
      rem  <= '0;
      step <= STEP_W'(DVD_W - 1);
    end else if (busy) begin
      dvd  <= {dvd[DVD_W-2:0], 1'b0};
      rem  <= qbit ? trial_sub[DVS_W-1:0] : trial[DVS_W-1:0];
      quo  <= {quo[QUO_W-2:0], qbit};
      step <= step - STEP_W'(1);
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = quo;

endmodule

// File: tb/sv/coulomb_pulse_counter_test.sv
// ----------------------------------------------------------------------------
// coulomb_pulse_counter_test: self-checking bench of the coulomb pulse counter
// Drives pulse, reset and read commands through the command channel, keeps a
// mirror of the counts, time stamps and registers, and compares every word on
// the result channel against the reading the mirror predicts. Directed cases
// cover power-up, wrapped and zero elapsed time, a missing polarity pin and
// divisor extremes; random phases follow under several register settings.
// ----------------------------------------------------------------------------
module coulomb_pulse_counter_test;
  import cpc_pkg::*;

  localparam int SETTLE_CYCLES = 200;
  localparam int TAIL_CYCLES   = 200;
  localparam int LIMIT_CYCLES  = 2000000;

  typedef struct packed {
    logic [MC_W-1:0]         chg_mc;
    logic [MC_W-1:0]         dis_mc;
    logic signed [AVG_W-1:0] avg;
    logic                    status;
  } reading_t;

  logic clk;
  logic rst;

  cpc_req_if cmd_bus ();
  cpc_rsp_if word_bus ();
  cpc_cfg_if reg_bus ();

  coulomb_pulse_counter uut (
    .clk (clk),
    .rst (rst),
    .req (cmd_bus),
    .rsp (word_bus),
    .cfg (reg_bus)
  );

  // mirror of the block state and registers
  logic [PPAH_W-1:0] ppah_mirror;
  logic              pin_wired;
  logic [CNT_W-1:0]  chg_pulses;
  logic [CNT_W-1:0]  dis_pulses;
  logic [SEC_W-1:0]  origin_sec;
  logic [SEC_W-1:0]  last_sec;

  reading_t          readings_due[$];
  int                faults;
  int                hold_cycles;
  int                cycles;
  logic              steady;
  logic [SEC_W-1:0]  wall_sec;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic int draw_gap();
    return steady ? 0 : int'($urandom_range(0, 6));
  endfunction

  function automatic logic [MC_W-1:0] to_mc(input logic [CNT_W-1:0] count);
    logic [63:0] scaled;
    if (ppah_mirror == '0) return '1;
    scaled = 64'(count) * 64'(MC_PER_AH) + 64'(ppah_mirror >> 1);
    return 32'(scaled / 64'(ppah_mirror));
  endfunction

  task automatic account_command(input logic [CMD_W-1:0] cmd, input logic level,
                                 input logic [SEC_W-1:0] now);
    reading_t    r;
    logic [31:0] span;
    logic [31:0] swing;
    longint      quo;
    r = '0;
    case (cmd)
      CMD_PULSE: begin
        if (pin_wired && level) chg_pulses += 1;
        else dis_pulses += 1;
        last_sec = now;
      end
      CMD_RESET: begin
        chg_pulses = '0;
        dis_pulses = '0;
        origin_sec = now;
        last_sec   = now;
      end
      default: begin
        r.chg_mc = to_mc(chg_pulses);
        r.dis_mc = to_mc(dis_pulses);
        if (cmd == CMD_READ_AVG) begin
          span = last_sec - origin_sec;
          if (span == '0) begin
            r.status = 1'b1;
          end else begin
            // signed 32-bit divide; -2^31 / -1 lands on 2^31, low half zero
            swing = (r.dis_mc - r.chg_mc) * 32'(DECI_PER_MILLI);
            quo   = longint'($signed(swing)) / longint'($signed(span));
            r.avg = quo[15:0];
          end
        end
        readings_due.push_back(r);
      end
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    faults++;
    $display("mismatch %s: got %08h expected %08h at cycle %0d", what, got, want, cycles);
  endtask

  // Hold valid across back-to-back words; drop it only when a gap is drawn.
  task automatic send_command(input logic [CMD_W-1:0] cmd, input logic level,
                              input logic [SEC_W-1:0] now);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      cmd_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_bus.valid          <= 1'b1;
    cmd_bus.command        <= cmd;
    cmd_bus.polarity_level <= level;
    cmd_bus.now_seconds    <= now;
    do @(posedge clk); while (!cmd_bus.ready);
    account_command(cmd, level, now);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DAT_W-1:0] value);
    reg_bus.valid <= 1'b1;
    reg_bus.index <= idx;
    reg_bus.data  <= value;
    do @(posedge clk); while (!reg_bus.ready);
    reg_bus.valid <= 1'b0;
    if (idx == CFG_PPAH) ppah_mirror = value;
    else pin_wired = value[0];
    @(posedge clk);
  endtask

  // Stop sending, wait for every reading, then let any pulse or reset finish.
  task automatic settle_idle();
    cmd_bus.valid <= 1'b0;
    while (readings_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic test_power_up();
    send_command(CMD_READ_CHG, 1'b0, 32'd0);
    send_command(CMD_READ_AVG, 1'b1, 32'hFFFF_FFFF);
  endtask

  task automatic test_pulse_counts();
    send_command(CMD_RESET, 1'b0, 32'd1000);
    send_command(CMD_PULSE, 1'b1, 32'd1001);
    send_command(CMD_PULSE, 1'b1, 32'd1002);
    send_command(CMD_PULSE, 1'b0, 32'd1003);
    send_command(CMD_READ_CHG, 1'b1, 32'd0);
    send_command(CMD_READ_AVG, 1'b0, 32'd0);
    for (int i = 0; i < 3; i++)
      send_command(CMD_PULSE, 1'b0, 32'd1005 + i);
    send_command(CMD_READ_AVG, 1'b1, 32'd0);
  endtask

  task automatic test_elapsed_edges();
    // zero elapsed time with nonzero counts
    send_command(CMD_RESET, 1'b1, 32'hFFFF_FFFF);
    send_command(CMD_PULSE, 1'b0, 32'hFFFF_FFFF);
    send_command(CMD_READ_AVG, 1'b0, 32'd0);
    // elapsed time wraps past zero
    send_command(CMD_PULSE, 1'b1, 32'h0000_0010);
    send_command(CMD_READ_AVG, 1'b0, 32'd0);
    // last stamp one second before start: elapsed time of all ones
    send_command(CMD_RESET, 1'b0, 32'd7);
    send_command(CMD_PULSE, 1'b0, 32'd6);
    send_command(CMD_READ_AVG, 1'b1, 32'd0);
  endtask

  task automatic test_missing_pin();
    settle_idle();
    write_reg(CFG_POLARITY, CFG_DAT_W'(0));
    send_command(CMD_RESET, 1'b1, 32'd50);
    send_command(CMD_PULSE, 1'b1, 32'd60);
    send_command(CMD_PULSE, 1'b1, 32'd61);
    send_command(CMD_READ_AVG, 1'b1, 32'd0);
    settle_idle();
    write_reg(CFG_POLARITY, CFG_DAT_W'(1));
  endtask

  task automatic test_divisor_extremes();
    settle_idle();
    write_reg(CFG_PPAH, 16'd0);
    send_command(CMD_READ_AVG, 1'b0, 32'd0);
    settle_idle();
    write_reg(CFG_PPAH, 16'd1);
    send_command(CMD_READ_CHG, 1'b0, 32'd0);
    settle_idle();
    write_reg(CFG_PPAH, 16'hFFFF);
    send_command(CMD_READ_AVG, 1'b0, 32'd0);
    settle_idle();
    write_reg(CFG_PPAH, 16'd3);
    send_command(CMD_READ_AVG, 1'b0, 32'd0);
  endtask

  task automatic run_random_phase(input int items, input int reset_pct, input int read_pct);
    int                roll;
    logic [CMD_W-1:0]  cmd;
    logic [SEC_W-1:0]  now;
    for (int i = 0; i < items; i++) begin
      if (i % 40 == 0) steady = ($urandom_range(0, 3) == 0);
      roll = $urandom_range(0, 99);
      if (roll < reset_pct) cmd = CMD_RESET;
      else if (roll < reset_pct + read_pct)
        cmd = $urandom_range(0, 1) ? CMD_READ_CHG : CMD_READ_AVG;
      else cmd = CMD_PULSE;
      // mostly advance the clock slowly, now and then jump anywhere
      if ($urandom_range(0, 9) == 0) wall_sec = $urandom();
      else wall_sec += $urandom_range(0, 3);
      now = (cmd == CMD_PULSE || cmd == CMD_RESET) ? wall_sec : $urandom();
      send_command(cmd, 1'($urandom_range(0, 1)), now);
    end
    steady = 1'b0;
  endtask

  task automatic test_random_traffic();
    // long accumulation at the smallest divisor: the converted count outgrows
    // 32 bits once past about 1194 pulses
    settle_idle();
    write_reg(CFG_PPAH, 16'd1);
    write_reg(CFG_POLARITY, CFG_DAT_W'(0));
    run_random_phase(1300, 0, 5);
    for (int p = 0; p < 4; p++) begin
      settle_idle();
      case (p)
        0:       write_reg(CFG_PPAH, 16'hFFFF);
        1:       write_reg(CFG_PPAH, 16'($urandom_range(1, 65535)));
        2:       write_reg(CFG_PPAH, 16'($urandom_range(1, 64)));
        default: write_reg(CFG_PPAH, 16'd3072);
      endcase
      write_reg(CFG_POLARITY, CFG_DAT_W'(p != 2));
      run_random_phase(150, 6, 44);
    end
  endtask

  // result side: draw a stall after each word
  always @(posedge clk) begin : stall_words
    int gap;
    if (rst) begin
      word_bus.ready <= 1'b0;
      hold_cycles    <= 0;
    end else if (word_bus.valid && word_bus.ready) begin
      gap = draw_gap();
      if (gap > 0) begin
        word_bus.ready <= 1'b0;
        hold_cycles    <= gap;
      end
    end else if (!word_bus.ready) begin
      if (hold_cycles <= 1) word_bus.ready <= 1'b1;
      else hold_cycles <= hold_cycles - 1;
    end
  end

  always @(posedge clk) begin : check_words
    reading_t due;
    if (!rst && word_bus.valid && word_bus.ready) begin
      if (readings_due.size() == 0) begin
        report_mismatch("unexpected word", word_bus.charge_millicoulomb, '0);
      end else begin
        due = readings_due.pop_front();
        if (word_bus.charge_millicoulomb !== due.chg_mc)
          report_mismatch("charge_millicoulomb", word_bus.charge_millicoulomb, due.chg_mc);
        if (word_bus.discharge_millicoulomb !== due.dis_mc)
          report_mismatch("discharge_millicoulomb", word_bus.discharge_millicoulomb,
                          due.dis_mc);
        if (word_bus.avg_current_deci_ma !== due.avg)
          report_mismatch("avg_current_deci_ma", 32'(word_bus.avg_current_deci_ma),
                          32'(due.avg));
        if (word_bus.status !== due.status)
          report_mismatch("status", 32'(word_bus.status), 32'(due.status));
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    rst                    <= 1'b1;
    cmd_bus.valid          <= 1'b0;
    cmd_bus.command        <= CMD_PULSE;
    cmd_bus.polarity_level <= 1'b0;
    cmd_bus.now_seconds    <= '0;
    reg_bus.valid          <= 1'b0;
    reg_bus.index          <= CFG_PPAH;
    reg_bus.data           <= '0;
    steady      = 1'b0;
    wall_sec    = '0;
    ppah_mirror = 16'd3072;
    pin_wired   = 1'b1;
    chg_pulses  = '0;
    dis_pulses  = '0;
    origin_sec  = '0;
    last_sec    = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_power_up();
    test_pulse_counts();
    test_elapsed_edges();
    test_missing_pin();
    test_divisor_extremes();
    test_random_traffic();

    cmd_bus.valid <= 1'b0;
    while (readings_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (faults == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
